### hdl/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define QDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, switched off while reset is held.
`define QDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is checked during reset as well.
`define QDC_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/qdc_pkg.sv
// Package of the quadrature detent counter: codes, reset values and the step table.
package qdc_pkg;

  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_STEP    = 2'd1;

  localparam logic [31:0] PAUSE_LENGTH_RESET = 32'd25000;
  localparam logic [7:0]  FAST_STEP_RESET    = 8'd10;
  localparam logic [1:0]  PINS_RESET         = 2'b11;

  localparam logic signed [3:0] DETENT_MAX = 4'sd3;
  localparam logic signed [3:0] DETENT_MIN = -4'sd3;

  typedef enum logic [1:0] {
    MOVED_NONE = 2'd0,
    MOVED_FWD  = 2'd1,
    MOVED_BWD  = 2'd2
  } moved_t;

  // Standard quadrature transition table, indexed by {previous A, B, current A, B}.
  function automatic logic signed [1:0] step_of(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

### hdl/qdc_channels.sv
// Handshake channel interfaces for samples, results and configuration writes.
interface qdc_in_if;
  logic        valid;
  logic        ready;
  logic        pin_a;
  logic        pin_b;
  logic [31:0] time_us;
  modport source (output valid, pin_a, pin_b, time_us, input ready);
  modport sink (input valid, pin_a, pin_b, time_us, output ready);
endinterface

interface qdc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] count;
  logic [1:0]  moved;
  logic        fast;
  modport source (output valid, count, moved, fast, input ready);
  modport sink (input valid, count, moved, fast, output ready);
endinterface

interface qdc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [qdc_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                 data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/quadrature_detent_counter.sv
// A sample request is held in the input register, and its result then in the result register.
// Throughput: one sample per cycle; the input register and the result register each move
// on when the stage after them is empty or being emptied.
// Reset (rst_n low, synchronous) empties both stages and restores pins high, a clear
// accumulator, zero timestamps and position, and the default configuration values.
module quadrature_detent_counter (
  input  logic     clk,
  input  logic     rst_n,
  qdc_in_if.sink   in_ch,
  qdc_out_if.source out_ch,
  qdc_cfg_if.sink  cfg_ch
);

  // Configuration registers: the user must write only while the block is idle; not enforced.
  logic [31:0] pause_length_r;
  logic [7:0]  fast_step_r;

  // Input stage: the sample request as it was accepted.
  logic        s1_valid_r;
  logic [1:0]  s1_pins_r;
  logic [31:0] s1_time_r;

  // Decoder state.
  logic [1:0]        prev_pins_r, prev_pins_nxt;
  logic signed [3:0] detent_sum_r, detent_sum_nxt;
  logic [31:0]       last_up_r, last_up_nxt;
  logic [31:0]       last_down_r, last_down_nxt;
  logic [31:0]       position_r, position_nxt;

  // Result stage.
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_count_r;
  qdc_pkg::moved_t out_moved_r, out_moved_nxt;
  logic        out_fast_r, out_fast_nxt;

  logic              advance;
  logic signed [1:0] step;
  logic signed [3:0] sum;
  logic [31:0]       up_elapsed, down_elapsed;
  logic              up_fast, down_fast;
  logic [31:0]       pos_plus_one, pos_plus_fast, pos_minus_one, pos_minus_fast;

  // The input stage moves on whenever the result register is free or is being read.
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pause_length_r <= qdc_pkg::PAUSE_LENGTH_RESET;
      fast_step_r    <= qdc_pkg::FAST_STEP_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        qdc_pkg::REG_PAUSE_LENGTH: pause_length_r <= cfg_ch.data;
        qdc_pkg::REG_FAST_STEP:    fast_step_r    <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_pins_r <= {in_ch.pin_a, in_ch.pin_b};
      s1_time_r <= in_ch.time_us;
    end
  end

  // The transition of the pin pair gives the step; four steps in one direction make a detent.
  assign step = qdc_pkg::step_of({prev_pins_r, s1_pins_r});
  assign sum  = detent_sum_r + {{2{step[1]}}, step};

  // The elapsed time wraps with the timestamp, so a plain 32-bit difference is right.
  assign up_elapsed   = s1_time_r - last_up_r;
  assign down_elapsed = s1_time_r - last_down_r;
  assign up_fast      = up_elapsed < pause_length_r;
  assign down_fast    = down_elapsed < pause_length_r;

  // All four candidate positions are formed side by side, so only a select follows the compare.
  assign pos_plus_one   = position_r + 32'd1;
  assign pos_minus_one  = position_r - 32'd1;
  assign pos_plus_fast  = position_r + {24'd0, fast_step_r};
  assign pos_minus_fast = position_r - {24'd0, fast_step_r};

  always_comb begin
    prev_pins_nxt  = prev_pins_r;
    detent_sum_nxt = detent_sum_r;
    last_up_nxt    = last_up_r;
    last_down_nxt  = last_down_r;
    position_nxt   = position_r;
    out_moved_nxt  = qdc_pkg::MOVED_NONE;
    out_fast_nxt   = 1'b0;
    if (advance) begin
      prev_pins_nxt  = s1_pins_r;
      detent_sum_nxt = sum;
      if (sum > qdc_pkg::DETENT_MAX) begin
        out_moved_nxt  = qdc_pkg::MOVED_FWD;
        out_fast_nxt   = up_fast;
        position_nxt   = up_fast ? pos_plus_fast : pos_plus_one;
        last_up_nxt    = s1_time_r;
        detent_sum_nxt = 4'sd0;
      end else if (sum < qdc_pkg::DETENT_MIN) begin
        out_moved_nxt  = qdc_pkg::MOVED_BWD;
        out_fast_nxt   = down_fast;
        position_nxt   = down_fast ? pos_minus_fast : pos_minus_one;
        last_down_nxt  = s1_time_r;
        detent_sum_nxt = 4'sd0;
      end
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pins_r  <= qdc_pkg::PINS_RESET;
      detent_sum_r <= 4'sd0;
      last_up_r    <= 32'd0;
      last_down_r  <= 32'd0;
      position_r   <= 32'd0;
      out_valid_r  <= 1'b0;
    end else begin
      prev_pins_r  <= prev_pins_nxt;
      detent_sum_r <= detent_sum_nxt;
      last_up_r    <= last_up_nxt;
      last_down_r  <= last_down_nxt;
      position_r   <= position_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // The result payload needs no reset; it is loaded whenever a sample moves on.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_count_r <= position_nxt;
      out_moved_r <= out_moved_nxt;
      out_fast_r  <= out_fast_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.count = out_count_r;
  assign out_ch.moved = out_moved_r;
  assign out_ch.fast  = out_fast_r;

endmodule

### hdl/qdc_checker.sv
// Port-level checker for the quadrature detent counter and its bind.
`include "assert_macros.svh"

module qdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_count,
  input logic [1:0]  out_moved,
  input logic        out_fast
);

  `QDC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_count))
  `QDC_ASSERT_IMP(a_moved_code, clk, rst_n, out_valid, out_moved == qdc_pkg::MOVED_NONE || out_moved == qdc_pkg::MOVED_FWD || out_moved == qdc_pkg::MOVED_BWD)
  `QDC_ASSERT_IMP(a_fast_needs_move, clk, rst_n, out_valid && out_fast, out_moved != qdc_pkg::MOVED_NONE)
  `QDC_ASSERT_NXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind quadrature_detent_counter qdc_checker u_qdc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_count (out_ch.count),
  .out_moved (out_ch.moved),
  .out_fast  (out_ch.fast)
);
